>>> rtl/tlsch_pkg.sv
// Shared types and constants for the TLS record / ClientHello parser.
// No dependencies; used by tlsch_cfg and tls_record_client_hello_parser.
package tlsch_pkg;

    typedef enum logic [3:0] {
        PH_REC, PH_HS, PH_VER, PH_RANDOM, PH_SIDLEN, PH_SID, PH_SUITELEN,
        PH_SUITES, PH_COMPLEN, PH_COMP, PH_EXTLEN, PH_DONE, PH_ERR
    } phase_t;

    localparam logic [3:0] V_ACCEPT        = 4'd0;
    localparam logic [3:0] V_TRUNCATED     = 4'd1;
    localparam logic [3:0] V_BAD_VERSION   = 4'd2;
    localparam logic [3:0] V_BAD_CONTENT   = 4'd3;
    localparam logic [3:0] V_SHORT_RECORD  = 4'd4;
    localparam logic [3:0] V_HS_OVERRUN    = 4'd5;
    localparam logic [3:0] V_BAD_HS_TYPE   = 4'd6;
    localparam logic [3:0] V_HELLO_SHORT   = 4'd7;
    localparam logic [3:0] V_FIXED_OVERRUN = 4'd8;
    localparam logic [3:0] V_SID_OVERRUN   = 4'd9;
    localparam logic [3:0] V_SUITE_OVERRUN = 4'd10;
    localparam logic [3:0] V_SUITE_ODD     = 4'd11;
    localparam logic [3:0] V_SUITE_MISSING = 4'd12;
    localparam logic [3:0] V_COMP_OVERRUN  = 4'd13;
    localparam logic [3:0] V_EXT_OVERRUN   = 4'd14;

    localparam logic [7:0] CT_CHANGE_CIPHER = 8'd20;
    localparam logic [7:0] CT_ALERT         = 8'd21;
    localparam logic [7:0] CT_HANDSHAKE     = 8'd22;
    localparam logic [7:0] CT_APP_DATA      = 8'd23;
    localparam logic [7:0] HT_CLIENT_HELLO  = 8'd1;

    localparam logic [1:0] REG_WANTED_SUITE = 2'd0;
    localparam logic [1:0] REG_RECORD_VER   = 2'd1;
    localparam logic [1:0] REG_MIN_HELLO    = 2'd2;

    localparam logic [15:0] RST_WANTED_SUITE = 16'hC013;
    localparam logic [15:0] RST_RECORD_VER   = 16'h0303;
    localparam logic [7:0]  RST_MIN_HELLO    = 8'd40;

    localparam logic [16:0] OFFSET_MAX  = 17'h1FFFF;
    localparam logic [16:0] REC_HDR_LEN = 17'd5;
    localparam logic [15:0] RANDOM_LEN  = 16'd32;

    typedef struct packed {
        logic [15:0] wanted_suite;
        logic [15:0] record_version;
        logic [7:0]  min_hello;
    } cfg_t;

    typedef struct packed {
        logic        suite_found;
        logic [15:0] ext_len;
        logic [7:0]  comp_len;
        logic [15:0] suite_len;
        logic [7:0]  sid_len;
        logic [15:0] hello_version;
        logic [7:0]  hs_type;
        logic [7:0]  content_type;
        logic [15:0] record_version;
    } fields_t;

endpackage

>>> rtl/tlsch_cfg.sv
// APB register file for the parser: wanted suite, record version, min hello length.
// Depends on tlsch_pkg.
module tlsch_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tlsch_pkg::cfg_t    cfg
);

    tlsch_pkg::cfg_t cfg_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wanted_suite   <= tlsch_pkg::RST_WANTED_SUITE;
            cfg_reg.record_version <= tlsch_pkg::RST_RECORD_VER;
            cfg_reg.min_hello      <= tlsch_pkg::RST_MIN_HELLO;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                tlsch_pkg::REG_WANTED_SUITE: cfg_reg.wanted_suite   <= pwdata[15:0];
                tlsch_pkg::REG_RECORD_VER:   cfg_reg.record_version <= pwdata[15:0];
                tlsch_pkg::REG_MIN_HELLO:    cfg_reg.min_hello      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tlsch_pkg::REG_WANTED_SUITE: prdata = {16'd0, cfg_reg.wanted_suite};
            tlsch_pkg::REG_RECORD_VER:   prdata = {16'd0, cfg_reg.record_version};
            tlsch_pkg::REG_MIN_HELLO:    prdata = {24'd0, cfg_reg.min_hello};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/tls_record_client_hello_parser.sv
// TLS record and ClientHello parser, one frame byte per beat.
// A result beat appears in the cycle after the frame's last byte is accepted.
// Throughput: one byte per cycle; the next byte is taken while a result waits,
// as long as the result register is empty or being drained that cycle.
// Reset (synchronous, aresetn low) clears frame state, empties the result register
// and loads the register defaults. Depends on tlsch_pkg and tlsch_cfg.
module tls_record_client_hello_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] verdict, [11:4] content_type, [19:12] handshake_type,
    // [35:20] hello_version, [43:36] session_id_length, [59:44] suite_list_length,
    // [67:60] compression_length, [83:68] extensions_length, [84] suite_found
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tlsch_pkg::cfg_t    cfg;
    tlsch_pkg::phase_t  phase_reg, phase_next;
    logic [16:0]        offset_reg, offset_next;
    logic [15:0]        fr_reg, fr_next;        // bytes left in the current field
    logic [23:0]        body_reg, body_next;    // bytes left in the hello body
    logic [15:0]        rl_reg, rl_next;        // record length
    logic [7:0]         pend_reg, pend_next;    // high byte of a 16-bit field
    logic [3:0]         err_reg, err_next;
    tlsch_pkg::fields_t f_reg, f_next;
    logic               m_valid_reg;
    logic [87:0]        m_data_reg;
    logic [3:0]         verdict;
    logic               s_acc;
    logic [7:0]         b;
    logic [23:0]        body_dec;
    logic [15:0]        fr_dec;
    logic [15:0]        pair_val;

    tlsch_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Output register parts the two sides: take a byte whenever the slot is free
    // or drains this cycle.
    assign s_tready = ~m_valid_reg | m_tready;
    assign s_acc    = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign b        = s_tdata;
    assign body_dec = body_reg - 24'd1;
    assign fr_dec   = (fr_reg == 16'd0) ? 16'd0 : fr_reg - 16'd1;
    assign pair_val = {pend_reg, b};

    // Per-byte parse step: next frame state from current state and the byte.
    always_comb begin
        phase_next  = phase_reg;
        fr_next     = fr_reg;
        body_next   = body_reg;
        rl_next     = rl_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        f_next      = f_reg;
        offset_next = (offset_reg == tlsch_pkg::OFFSET_MAX) ? offset_reg
                                                            : offset_reg + 17'd1;
        unique case (phase_reg)
            tlsch_pkg::PH_REC: begin
                if (offset_reg == 17'd0) begin
                    f_next.content_type = b;
                end else if (offset_reg <= 17'd2) begin
                    f_next.record_version = {f_reg.record_version[7:0], b};
                end else if (offset_reg == 17'd3) begin
                    rl_next = {8'd0, b};
                end else begin
                    rl_next = {rl_reg[7:0], b};
                    if (f_reg.record_version != cfg.record_version) begin
                        err_next = tlsch_pkg::V_BAD_VERSION;   phase_next = tlsch_pkg::PH_ERR;
                    end else if (f_reg.content_type == tlsch_pkg::CT_HANDSHAKE) begin
                        if (rl_next < 16'd4) begin
                            err_next = tlsch_pkg::V_SHORT_RECORD; phase_next = tlsch_pkg::PH_ERR;
                        end else begin
                            phase_next = tlsch_pkg::PH_HS;
                        end
                    end else if (f_reg.content_type == tlsch_pkg::CT_CHANGE_CIPHER
                              || f_reg.content_type == tlsch_pkg::CT_ALERT
                              || f_reg.content_type == tlsch_pkg::CT_APP_DATA) begin
                        phase_next = tlsch_pkg::PH_DONE;
                    end else begin
                        err_next = tlsch_pkg::V_BAD_CONTENT;   phase_next = tlsch_pkg::PH_ERR;
                    end
                end
            end
            tlsch_pkg::PH_HS: begin
                if (offset_reg == 17'd5) begin
                    f_next.hs_type = b;
                    body_next      = 24'd0;
                end else begin
                    body_next = {body_reg[15:0], b};
                    if (offset_reg == 17'd8) begin
                        if ({1'b0, body_next} + 25'd4 > {9'd0, rl_reg}) begin
                            err_next = tlsch_pkg::V_HS_OVERRUN; phase_next = tlsch_pkg::PH_ERR;
                        end else if (f_reg.hs_type == tlsch_pkg::HT_CLIENT_HELLO) begin
                            if (body_next < {16'd0, cfg.min_hello}) begin
                                err_next = tlsch_pkg::V_HELLO_SHORT;
                                phase_next = tlsch_pkg::PH_ERR;
                            end else begin
                                phase_next = tlsch_pkg::PH_VER;
                                fr_next    = 16'd2;
                            end
                        end else if (f_reg.hs_type == 8'd0 || f_reg.hs_type == 8'd2
                                  || (f_reg.hs_type >= 8'd11 && f_reg.hs_type <= 8'd16)
                                  || f_reg.hs_type == 8'd20) begin
                            phase_next = tlsch_pkg::PH_DONE;
                        end else begin
                            err_next = tlsch_pkg::V_BAD_HS_TYPE; phase_next = tlsch_pkg::PH_ERR;
                        end
                    end
                end
            end
            tlsch_pkg::PH_VER, tlsch_pkg::PH_RANDOM, tlsch_pkg::PH_SIDLEN,
            tlsch_pkg::PH_SUITELEN, tlsch_pkg::PH_COMPLEN, tlsch_pkg::PH_EXTLEN: begin
                // Fixed hello fields must fit inside the declared body.
                if (body_reg == 24'd0) begin
                    err_next = tlsch_pkg::V_FIXED_OVERRUN; phase_next = tlsch_pkg::PH_ERR;
                end else begin
                    body_next = body_dec;
                    if (phase_reg == tlsch_pkg::PH_RANDOM) begin
                        fr_next = fr_dec;
                        if (fr_dec == 16'd0) phase_next = tlsch_pkg::PH_SIDLEN;
                    end else if (phase_reg == tlsch_pkg::PH_SIDLEN) begin
                        f_next.sid_len = b;
                        if ({16'd0, b} > body_dec) begin
                            err_next = tlsch_pkg::V_SID_OVERRUN; phase_next = tlsch_pkg::PH_ERR;
                        end else if (b == 8'd0) begin
                            phase_next = tlsch_pkg::PH_SUITELEN; fr_next = 16'd2;
                        end else begin
                            phase_next = tlsch_pkg::PH_SID;      fr_next = {8'd0, b};
                        end
                    end else if (phase_reg == tlsch_pkg::PH_COMPLEN) begin
                        f_next.comp_len = b;
                        if ({16'd0, b} > body_dec) begin
                            err_next = tlsch_pkg::V_COMP_OVERRUN; phase_next = tlsch_pkg::PH_ERR;
                        end else if (b == 8'd0) begin
                            phase_next = tlsch_pkg::PH_EXTLEN; fr_next = 16'd2;
                        end else begin
                            phase_next = tlsch_pkg::PH_COMP;   fr_next = {8'd0, b};
                        end
                    end else if (fr_reg >= 16'd2) begin
                        // High byte of a big-endian pair.
                        pend_next = b;
                        fr_next   = 16'd1;
                    end else begin
                        fr_next = 16'd0;
                        if (phase_reg == tlsch_pkg::PH_VER) begin
                            f_next.hello_version = pair_val;
                            phase_next = tlsch_pkg::PH_RANDOM;
                            fr_next    = tlsch_pkg::RANDOM_LEN;
                        end else if (phase_reg == tlsch_pkg::PH_SUITELEN) begin
                            f_next.suite_len = pair_val;
                            if ({8'd0, pair_val} > body_dec) begin
                                err_next = tlsch_pkg::V_SUITE_OVERRUN;
                                phase_next = tlsch_pkg::PH_ERR;
                            end else if (pair_val[0]) begin
                                err_next = tlsch_pkg::V_SUITE_ODD; phase_next = tlsch_pkg::PH_ERR;
                            end else if (pair_val == 16'd0) begin
                                err_next = tlsch_pkg::V_SUITE_MISSING;
                                phase_next = tlsch_pkg::PH_ERR;
                            end else begin
                                phase_next = tlsch_pkg::PH_SUITES; fr_next = pair_val;
                            end
                        end else begin
                            f_next.ext_len = pair_val;
                            if ({8'd0, pair_val} > body_dec) begin
                                err_next = tlsch_pkg::V_EXT_OVERRUN;
                                phase_next = tlsch_pkg::PH_ERR;
                            end else begin
                                phase_next = tlsch_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
            tlsch_pkg::PH_SID, tlsch_pkg::PH_COMP: begin
                if (body_reg != 24'd0) body_next = body_dec;
                fr_next = fr_dec;
                if (fr_dec == 16'd0) begin
                    phase_next = (phase_reg == tlsch_pkg::PH_SID) ? tlsch_pkg::PH_SUITELEN
                                                                  : tlsch_pkg::PH_EXTLEN;
                    fr_next = 16'd2;
                end
            end
            tlsch_pkg::PH_SUITES: begin
                if (body_reg != 24'd0) body_next = body_dec;
                if (!fr_reg[0]) begin
                    pend_next = b;
                end else if (pair_val == cfg.wanted_suite) begin
                    f_next.suite_found = 1'b1;
                end
                fr_next = fr_dec;
                if (fr_dec == 16'd0) begin
                    if (!f_next.suite_found) begin
                        err_next = tlsch_pkg::V_SUITE_MISSING; phase_next = tlsch_pkg::PH_ERR;
                    end else begin
                        phase_next = tlsch_pkg::PH_COMPLEN;
                    end
                end
            end
            default: ;  // done or error: ignore trailing bytes
        endcase
    end

    // Verdict at the frame's last byte; truncation wins over everything else.
    always_comb begin
        if (offset_next < tlsch_pkg::REC_HDR_LEN
            || offset_next < tlsch_pkg::REC_HDR_LEN + {1'b0, rl_next}) begin
            verdict = tlsch_pkg::V_TRUNCATED;
        end else if (phase_next == tlsch_pkg::PH_ERR) begin
            verdict = err_next;
        end else if (phase_next == tlsch_pkg::PH_DONE) begin
            verdict = tlsch_pkg::V_ACCEPT;
        end else begin
            verdict = tlsch_pkg::V_TRUNCATED;
        end
    end

    // Frame state: advance per accepted byte, clear after the last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (s_acc && s_tlast)) begin
            phase_reg  <= tlsch_pkg::PH_REC;
            offset_reg <= 17'd0;
            fr_reg     <= 16'd0;
            body_reg   <= 24'd0;
            rl_reg     <= 16'd0;
            pend_reg   <= 8'd0;
            err_reg    <= 4'd0;
            f_reg      <= '0;
        end else if (s_acc) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            fr_reg     <= fr_next;
            body_reg   <= body_next;
            rl_reg     <= rl_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
            f_reg      <= f_next;
        end
    end

    // Result register: load on the last byte, drop once the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tlast) begin
            m_data_reg <= {3'd0, f_next.suite_found, f_next.ext_len, f_next.comp_len,
                           f_next.suite_len, f_next.sid_len, f_next.hello_version,
                           f_next.hs_type, f_next.content_type, verdict};
        end
    end

    // An error phase always carries a nonzero reason.
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tlsch_pkg::PH_ERR |-> err_reg != 4'd0)
        else $error("error phase without reason code");

    // The last byte of a frame restarts the parse.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> offset_reg == 17'd0 && phase_reg == tlsch_pkg::PH_REC)
        else $error("frame state not cleared after last byte");

    // An accepted ClientHello must have offered the wanted suite.
    a_hello_suite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3:0] == tlsch_pkg::V_ACCEPT
        && m_data_reg[11:4] == tlsch_pkg::CT_HANDSHAKE
        && m_data_reg[19:12] == tlsch_pkg::HT_CLIENT_HELLO |-> m_data_reg[84])
        else $error("ClientHello accepted without wanted suite");

endmodule
